>>> rtl/core/tcw_pkg.sv
// Shared constants, request codes and types for the text console writer.
`timescale 1ns / 1ps

package tcw_pkg;

    // Screen geometry
    localparam int COLS   = 80;
    localparam int ROWS   = 25;
    localparam int NCELLS = COLS * ROWS;

    // Field widths
    localparam int REQ_W  = 2;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int SET_W  = 8;
    localparam int IDX_W  = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int LIN_W  = 11;
    localparam int CELL_W = ATTR_W + CHAR_W;

    // Cell memory addressing; the sweep pointer must also hold NCELLS itself
    localparam int RAM_AW = $clog2(NCELLS);
    localparam int PTR_W  = $clog2(NCELLS + 1);

    // Request codes
    localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SET   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_TEXT_ATTR = 1'b0;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [CHAR_W-1:0] char_code;
        logic [SET_W-1:0]  set_col;
        logic [SET_W-1:0]  set_row;
        logic [IDX_W-1:0]  cell_index;
    } tcw_req_t;

    typedef struct packed {
        logic [COL_W-1:0]  cursor_col;
        logic [ROW_W-1:0]  cursor_row;
        logic [LIN_W-1:0]  cursor_linear;
        logic [CELL_W-1:0] cell_data;
        logic              did_scroll;
    } tcw_result_t;

endpackage

>>> rtl/core/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/tcw_engine.sv
// Request sequencer: cursor state, sweep pointer and the cell memory.
`timescale 1ns / 1ps

module tcw_engine (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  tcw_pkg::tcw_req_t         req,
    input  logic [tcw_pkg::ATTR_W-1:0] text_attr,
    output logic                      res_valid,
    input  logic                      res_ready,
    output tcw_pkg::tcw_result_t      res
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_COPY = 3'd2;
    localparam logic [2:0] ST_FILL = 3'd3;
    localparam logic [2:0] ST_RESP = 3'd4;

    localparam logic [LIN_W-1:0] COLS_L    = LIN_W'(COLS);
    localparam logic [COL_W:0]   COL_END   = (COL_W + 1)'(COLS);
    localparam logic [ROW_W:0]   ROW_END   = (ROW_W + 1)'(ROWS);
    localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST  = ROW_W'(ROWS - 1);
    localparam logic [SET_W-1:0] SCOL_LAST = SET_W'(COLS - 1);
    localparam logic [SET_W-1:0] SROW_LAST = SET_W'(ROWS - 1);
    localparam logic [PTR_W-1:0] PTR_COLS  = PTR_W'(COLS);
    localparam logic [PTR_W-1:0] PTR_BACK  = PTR_W'(COLS + 1);
    localparam logic [PTR_W-1:0] PTR_END   = PTR_W'(NCELLS);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(NCELLS - 1);
    localparam logic [PTR_W-1:0] PTR_BOT   = PTR_W'(NCELLS - COLS);
    localparam logic [IDX_W-1:0] IDX_END   = IDX_W'(NCELLS);

    logic [2:0]       state_reg, state_next;
    tcw_req_t         req_reg, req_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic             scroll_reg, scroll_next;

    logic [LIN_W-1:0] lin;
    logic [COL_W:0]   col_inc;
    logic [ROW_W:0]   row_inc;
    logic [ROW_W:0]   row_tmp;
    logic [PTR_W-1:0] copy_dst;
    logic             accept;

    logic              ram_we, ram_re;
    logic [RAM_AW-1:0] ram_waddr, ram_raddr;
    logic [CELL_W-1:0] ram_wdata, ram_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (NCELLS)
    ) u_cells (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared linear-position unit: pre-update cursor in EXEC, post-update in RESP
    assign lin      = LIN_W'(row_reg) * COLS_L + LIN_W'(col_reg);
    assign col_inc  = {1'b0, col_reg} + 1'b1;
    assign row_inc  = {1'b0, row_reg} + 1'b1;
    assign copy_dst = ptr_reg - PTR_BACK;

    assign req_ready = (state_reg == ST_IDLE) || ((state_reg == ST_RESP) && res_ready);
    assign accept    = req_valid && req_ready;
    assign res_valid = (state_reg == ST_RESP);

    always_comb begin
        res.cursor_col    = col_reg;
        res.cursor_row    = row_reg;
        res.cursor_linear = lin;
        res.did_scroll    = scroll_reg;
        if ((req_reg.req_type == REQ_READ) && (req_reg.cell_index < IDX_END)) begin
            res.cell_data = ram_rdata;
        end else begin
            res.cell_data = '0;
        end
    end

    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        ptr_next    = ptr_reg;
        scroll_next = scroll_reg;
        row_tmp     = {1'b0, row_reg};
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        ram_waddr   = '0;
        ram_raddr   = '0;
        ram_wdata   = '0;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    req_next   = req;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                scroll_next = 1'b0;
                state_next  = ST_RESP;
                case (req_reg.req_type)
                    REQ_PUT: begin
                        if (req_reg.char_code == NEWLINE_CODE) begin
                            col_next = '0;
                            row_tmp  = row_inc;
                        end else begin
                            ram_we    = 1'b1;
                            ram_waddr = lin[RAM_AW-1:0];
                            ram_wdata = {text_attr, req_reg.char_code};
                            if (col_inc == COL_END) begin
                                col_next = '0;
                                row_tmp  = row_inc;
                            end else begin
                                col_next = col_inc[COL_W-1:0];
                            end
                        end
                        if (row_tmp == ROW_END) begin
                            row_next    = ROW_LAST;
                            scroll_next = 1'b1;
                            ptr_next    = PTR_COLS;
                            state_next  = ST_COPY;
                        end else begin
                            row_next = row_tmp[ROW_W-1:0];
                        end
                    end
                    REQ_CLEAR: begin
                        col_next   = '0;
                        row_next   = '0;
                        ptr_next   = '0;
                        state_next = ST_FILL;
                    end
                    REQ_SET: begin
                        col_next = (req_reg.set_col > SCOL_LAST) ? COL_LAST
                                                                 : req_reg.set_col[COL_W-1:0];
                        row_next = (req_reg.set_row > SROW_LAST) ? ROW_LAST
                                                                 : req_reg.set_row[ROW_W-1:0];
                    end
                    REQ_READ: begin
                        ram_re    = (req_reg.cell_index < IDX_END);
                        ram_raddr = req_reg.cell_index[RAM_AW-1:0];
                    end
                    default: begin
                        state_next = ST_RESP;
                    end
                endcase
            end
            ST_COPY: begin
                // read one row ahead, write the previous read one row up
                ram_re    = (ptr_reg != PTR_END);
                ram_raddr = ptr_reg[RAM_AW-1:0];
                ram_we    = (ptr_reg != PTR_COLS);
                ram_waddr = copy_dst[RAM_AW-1:0];
                ram_wdata = ram_rdata;
                if (ptr_reg == PTR_END) begin
                    ptr_next   = PTR_BOT;
                    state_next = ST_FILL;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_FILL: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg[RAM_AW-1:0];
                ram_wdata = {text_attr, BLANK_CODE};
                if (ptr_reg == PTR_LAST) begin
                    state_next = ST_RESP;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            ST_RESP: begin
                if (res_ready) begin
                    if (req_valid) begin
                        req_next   = req;
                        state_next = ST_EXEC;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            col_reg    <= '0;
            row_reg    <= '0;
            scroll_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            scroll_reg <= scroll_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        ptr_reg <= ptr_next;
    end

endmodule

>>> rtl/core/text_console_char_writer.sv
// Top level of the text console writer: APB register, request and result ports.
`timescale 1ns / 1ps

// Text-mode console writer over an 80 by 25 screen of 16-bit cells (attribute
// byte high, character byte low), held in a single-port-write, single-port-read
// cell memory. Each request returns one result carrying the cursor after the
// request and its linear position row*80+col. Put, set cursor and read cell
// can follow one another back to back while results are taken; the result
// waits in an output register so a new request may enter while it is held.
// A put that scrolls walks the memory once, copying one cell per cycle and
// then blanking the bottom row; clear writes one blank per cycle. The single
// memory port sets this pace. Blank cells use the text_attribute register
// (APB offset 0, reset 0x07) with a space character.

module text_console_char_writer (
    input  logic                         aclk,
    input  logic                         aresetn,
    // APB configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [tcw_pkg::APB_AW-1:0]   paddr,
    input  logic [tcw_pkg::APB_DW-1:0]   pwdata,
    output logic [tcw_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // request channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [tcw_pkg::REQ_W-1:0]    s_req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]   s_char_code,
    input  logic [tcw_pkg::SET_W-1:0]    s_set_col,
    input  logic [tcw_pkg::SET_W-1:0]    s_set_row,
    input  logic [tcw_pkg::IDX_W-1:0]    s_cell_index,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [tcw_pkg::COL_W-1:0]    m_cursor_col,
    output logic [tcw_pkg::ROW_W-1:0]    m_cursor_row,
    output logic [tcw_pkg::LIN_W-1:0]    m_cursor_linear,
    output logic [tcw_pkg::CELL_W-1:0]   m_cell_data,
    output logic                         m_did_scroll
);
    import tcw_pkg::*;

    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic              m_valid_reg, m_valid_next;
    tcw_result_t       out_reg, out_next;

    tcw_req_t          req;
    tcw_result_t       res;
    logic              res_valid;
    logic              res_ready;
    logic              cfg_write;
    logic              reg_sel;

    assign pready    = 1'b1;
    assign reg_sel   = (paddr[APB_AW-1] == REG_TEXT_ATTR);
    assign cfg_write = psel && penable && pwrite && pready && reg_sel;
    assign prdata    = reg_sel ? {{(APB_DW - ATTR_W){1'b0}}, attr_reg} : '0;
    assign attr_next = cfg_write ? pwdata[ATTR_W-1:0] : attr_reg;

    assign req.req_type   = s_req_type;
    assign req.char_code  = s_char_code;
    assign req.set_col    = s_set_col;
    assign req.set_row    = s_set_row;
    assign req.cell_index = s_cell_index;

    tcw_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req_ready (s_ready),
        .req       (req),
        .text_attr (attr_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // hold the result until taken; load when empty or draining
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg    <= ATTR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            attr_reg    <= attr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_cursor_col    = out_reg.cursor_col;
    assign m_cursor_row    = out_reg.cursor_row;
    assign m_cursor_linear = out_reg.cursor_linear;
    assign m_cell_data     = out_reg.cell_data;
    assign m_did_scroll    = out_reg.did_scroll;

endmodule

>>> tb/sv/tb_text_console_char_writer.sv
// Self-checking testbench for the text console writer: directed and random requests.
`timescale 1ns / 1ps

module tb_text_console_char_writer;
    import tcw_pkg::*;

    localparam int RANDOM_PHASES   = 5;
    localparam int PHASE_REQUESTS  = 130;
    localparam int SETTLE_CYCLES   = 40;
    localparam logic [APB_AW-1:0] ATTR_ADDR = APB_AW'(REG_TEXT_ATTR) << 2;

    typedef struct {
        tcw_req_t    req;
        bit          fixed;
        tcw_result_t res;
    } console_step_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;
    logic                s_valid;
    logic                s_ready;
    logic [REQ_W-1:0]    s_req_type;
    logic [CHAR_W-1:0]   s_char_code;
    logic [SET_W-1:0]    s_set_col;
    logic [SET_W-1:0]    s_set_row;
    logic [IDX_W-1:0]    s_cell_index;
    logic                m_valid;
    logic                m_ready;
    logic [COL_W-1:0]    m_cursor_col;
    logic [ROW_W-1:0]    m_cursor_row;
    logic [LIN_W-1:0]    m_cursor_linear;
    logic [CELL_W-1:0]   m_cell_data;
    logic                m_did_scroll;

    // Mirror of the console state
    logic [CELL_W-1:0]   screen_mirror [NCELLS];
    int                  col_mirror;
    int                  row_mirror;
    logic [ATTR_W-1:0]   attr_mirror;

    tcw_result_t         expected_reports [$];
    console_step_t       directed_steps [$];
    tcw_result_t         want;
    int                  fault_count = 0;
    int                  sent_count = 0;
    bit                  src_calm = 1'b0;

    text_console_char_writer DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_char_code     (s_char_code),
        .s_set_col       (s_set_col),
        .s_set_row       (s_set_row),
        .s_cell_index    (s_cell_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cursor_col    (m_cursor_col),
        .m_cursor_row    (m_cursor_row),
        .m_cursor_linear (m_cursor_linear),
        .m_cell_data     (m_cell_data),
        .m_did_scroll    (m_did_scroll)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one request to the mirror and return the report it should produce
    function automatic tcw_result_t apply_console_request(input tcw_req_t rq);
        tcw_result_t       res;
        logic [CELL_W-1:0] blank;
        int                i;
        res   = '0;
        blank = {attr_mirror, BLANK_CODE};
        case (rq.req_type)
            REQ_PUT: begin
                if (rq.char_code == NEWLINE_CODE) begin
                    row_mirror++;
                    col_mirror = 0;
                end else begin
                    screen_mirror[row_mirror * COLS + col_mirror] = {attr_mirror, rq.char_code};
                    col_mirror++;
                end
                if (col_mirror >= COLS) begin
                    row_mirror++;
                    col_mirror = 0;
                end
                if (row_mirror >= ROWS) begin
                    for (i = 0; i < NCELLS - COLS; i++)
                        screen_mirror[i] = screen_mirror[i + COLS];
                    for (i = NCELLS - COLS; i < NCELLS; i++)
                        screen_mirror[i] = blank;
                    row_mirror       = ROWS - 1;
                    res.did_scroll   = 1'b1;
                end
            end
            REQ_CLEAR: begin
                for (i = 0; i < NCELLS; i++)
                    screen_mirror[i] = blank;
                col_mirror = 0;
                row_mirror = 0;
            end
            REQ_SET: begin
                col_mirror = (rq.set_col > COLS - 1) ? COLS - 1 : int'(rq.set_col);
                row_mirror = (rq.set_row > ROWS - 1) ? ROWS - 1 : int'(rq.set_row);
            end
            REQ_READ: begin
                if (rq.cell_index < NCELLS)
                    res.cell_data = screen_mirror[rq.cell_index];
            end
        endcase
        res.cursor_col    = COL_W'(col_mirror);
        res.cursor_row    = ROW_W'(row_mirror);
        res.cursor_linear = LIN_W'(row_mirror * COLS + col_mirror);
        return res;
    endfunction

    task automatic add_step(input logic [REQ_W-1:0] rt, input logic [CHAR_W-1:0] ch,
                            input logic [SET_W-1:0] sc, input logic [SET_W-1:0] sr,
                            input logic [IDX_W-1:0] idx, input bit fixed,
                            input int ecol, input int erow, input int elin,
                            input logic [CELL_W-1:0] edata, input bit escroll);
        console_step_t st;
        st.req.req_type       = rt;
        st.req.char_code      = ch;
        st.req.set_col        = sc;
        st.req.set_row        = sr;
        st.req.cell_index     = idx;
        st.fixed              = fixed;
        st.res.cursor_col     = COL_W'(ecol);
        st.res.cursor_row     = ROW_W'(erow);
        st.res.cursor_linear  = LIN_W'(elin);
        st.res.cell_data      = edata;
        st.res.did_scroll     = escroll;
        directed_steps.push_back(st);
    endtask

    // Present one request, hold it until taken, then record its expected report
    task automatic send_request(input tcw_req_t rq, input bit fixed,
                                input tcw_result_t fixed_res);
        int          gap;
        tcw_result_t predicted;
        @(negedge aclk);
        if (sent_count % 40 == 0)
            src_calm = ($urandom_range(0, 3) == 0);
        gap = src_calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_req_type   = rq.req_type;
        s_char_code  = rq.char_code;
        s_set_col    = rq.set_col;
        s_set_row    = rq.set_row;
        s_cell_index = rq.cell_index;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predicted = apply_console_request(rq);
        expected_reports.push_back(fixed ? fixed_res : predicted);
        sent_count++;
    endtask

    task automatic drain_reports();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_reports.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Write the attribute register, then read it back
    task automatic configure_attribute(input logic [ATTR_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ATTR_ADDR;
        pwdata  = APB_DW'(value);
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        attr_mirror = value;
        @(negedge aclk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== APB_DW'(value)) begin
            $error("text_attribute: expected %0h, got %0h", value, prdata);
            fault_count++;
        end
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_reports.size() == 0) begin
                $error("report with no request outstanding");
                fault_count++;
            end else begin
                want = expected_reports.pop_front();
                if (m_cursor_col !== want.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d", want.cursor_col, m_cursor_col);
                    fault_count++;
                end
                if (m_cursor_row !== want.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row, m_cursor_row);
                    fault_count++;
                end
                if (m_cursor_linear !== want.cursor_linear) begin
                    $error("cursor_linear: expected %0d, got %0d",
                           want.cursor_linear, m_cursor_linear);
                    fault_count++;
                end
                if (m_cell_data !== want.cell_data) begin
                    $error("cell_data: expected %0h, got %0h", want.cell_data, m_cell_data);
                    fault_count++;
                end
                if (m_did_scroll !== want.did_scroll) begin
                    $error("did_scroll: expected %0d, got %0d", want.did_scroll, m_did_scroll);
                    fault_count++;
                end
            end
        end
    end

    initial begin : result_sink
        int stall;
        int taken;
        bit calm;
        m_ready = 1'b0;
        taken   = 0;
        calm    = 1'b0;
        while (aresetn !== 1'b1)
            @(negedge aclk);
        forever begin
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 3) == 0);
            stall = calm ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        logic [ATTR_W-1:0] phase_attr [RANDOM_PHASES];
        tcw_req_t          rq;
        tcw_result_t       unused_res;
        int                pick;
        logic [CELL_W-1:0] reset_blank;
        aresetn      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        s_valid      = 1'b0;
        s_req_type   = REQ_PUT;
        s_char_code  = '0;
        s_set_col    = '0;
        s_set_row    = '0;
        s_cell_index = '0;
        unused_res   = '0;
        col_mirror   = 0;
        row_mirror   = 0;
        attr_mirror  = ATTR_RESET;
        reset_blank  = {ATTR_RESET, BLANK_CODE};
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        // Cells are undefined until the first clear: only the out-of-range read comes before it
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd2047, 1, 0, 0, 0, '0, 0);
        add_step(REQ_CLEAR, 8'h00, 8'd0,   8'd0,   11'd0,    1, 0, 0, 0, '0, 0);
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd0,    1, 0, 0, 0, reset_blank, 0);
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd1999, 1, 0, 0, 0, reset_blank, 0);
        add_step(REQ_PUT,   8'h41, 8'd0,   8'd0,   11'd0,    1, 1, 0, 1, '0, 0);
        add_step(REQ_PUT,   8'hFF, 8'd0,   8'd0,   11'd0,    0, 0, 0, 0, '0, 0);
        add_step(REQ_PUT,   8'h00, 8'd0,   8'd0,   11'd0,    0, 0, 0, 0, '0, 0);
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd0,    0, 0, 0, 0, '0, 0);
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd1,    0, 0, 0, 0, '0, 0);
        add_step(REQ_PUT,   NEWLINE_CODE, 8'd0, 8'd0, 11'd0, 1, 0, 1, 80, '0, 0);
        add_step(REQ_SET,   8'h00, 8'd255, 8'd255, 11'd0,    1, 79, 24, 1999, '0, 0);
        // last cell: wrap and scroll in one put
        add_step(REQ_PUT,   8'h5A, 8'd0,   8'd0,   11'd0,    1, 0, 24, 1920, '0, 1);
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd1919, 0, 0, 0, 0, '0, 0);
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd1999, 0, 0, 0, 0, '0, 0);
        add_step(REQ_SET,   8'h00, 8'd0,   8'd0,   11'd0,    1, 0, 0, 0, '0, 0);
        add_step(REQ_SET,   8'h00, 8'd79,  8'd0,   11'd0,    1, 79, 0, 79, '0, 0);
        add_step(REQ_PUT,   8'h78, 8'd0,   8'd0,   11'd0,    0, 0, 0, 0, '0, 0);
        add_step(REQ_SET,   8'h00, 8'd0,   8'd24,  11'd0,    0, 0, 0, 0, '0, 0);
        add_step(REQ_PUT,   NEWLINE_CODE, 8'd0, 8'd0, 11'd0, 0, 0, 0, 0, '0, 0);
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd2000, 0, 0, 0, 0, '0, 0);
        add_step(REQ_SET,   8'h00, 8'd80,  8'd25,  11'd0,    1, 79, 24, 1999, '0, 0);
        add_step(REQ_SET,   8'h00, 8'h55,  8'hAA,  11'd0,    0, 0, 0, 0, '0, 0);
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd1024, 0, 0, 0, 0, '0, 0);
        add_step(REQ_READ,  8'h00, 8'd0,   8'd0,   11'd1023, 0, 0, 0, 0, '0, 0);
        add_step(REQ_CLEAR, 8'h00, 8'd0,   8'd0,   11'd0,    0, 0, 0, 0, '0, 0);
        foreach (directed_steps[k])
            send_request(directed_steps[k].req, directed_steps[k].fixed, directed_steps[k].res);

        phase_attr[0] = 8'h00;
        phase_attr[1] = 8'hFF;
        phase_attr[2] = ATTR_W'($urandom_range(0, 255));
        phase_attr[3] = 8'hA5;
        phase_attr[4] = ATTR_RESET;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_reports();
            configure_attribute(phase_attr[p]);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                rq.char_code  = CHAR_W'($urandom_range(0, 255));
                rq.set_col    = SET_W'($urandom_range(0, 255));
                rq.set_row    = SET_W'($urandom_range(0, 255));
                rq.cell_index = IDX_W'($urandom_range(0, 2047));
                pick          = $urandom_range(0, 99);
                if (pick < 60) begin
                    rq.req_type = REQ_PUT;
                    if ($urandom_range(0, 7) == 0)
                        rq.char_code = NEWLINE_CODE;
                end else if (pick < 72) begin
                    // favour the bottom rows and line ends to reach wraps and scrolls
                    rq.req_type = REQ_SET;
                    if ($urandom_range(0, 1) == 0)
                        rq.set_col = SET_W'($urandom_range(70, 79));
                    if ($urandom_range(0, 9) < 4)
                        rq.set_row = SET_W'($urandom_range(20, 24));
                    else if ($urandom_range(0, 9) < 5)
                        rq.set_row = SET_W'($urandom_range(0, 24));
                end else if (pick < 97) begin
                    rq.req_type = REQ_READ;
                end else begin
                    rq.req_type = REQ_CLEAR;
                end
                send_request(rq, 1'b0, unused_res);
            end
        end
        drain_reports();

        if (expected_reports.size() != 0) begin
            $error("%0d reports never arrived", expected_reports.size());
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #(100_000_000);
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_engine.sv
rtl/core/text_console_char_writer.sv
tb/sv/tb_text_console_char_writer.sv
